/* hdl/ssme_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set merge engine package
// Shared widths, codes, controller states and the command and status words
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ssme_pkg;

  localparam int LIST_CAPACITY_DEF = 32;
  localparam int DATA_W            = 32;
  localparam int KIND_W            = 2;
  localparam int MODE_W            = 2;

  // Input word kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

  // Operating modes held in the mode register.
  localparam logic [MODE_W-1:0] MODE_INTERSECT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DIFF      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUBSET    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic active;
    logic out_free;
  } status_t;

endpackage

/* hdl/ssme_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel interface
// Carries load and run words into the engine with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssme_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic signed [31:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

/* hdl/ssme_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel interface
// Carries result words out of the engine with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssme_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] value_res;
  logic        has_value;
  logic        contained;
  logic        overflow;
  logic        last;

  modport source (output valid, output value_res, output has_value, output contained,
                  output overflow, output last, input ready);
  modport sink   (input valid, input value_res, input has_value, input contained,
                  input overflow, input last, output ready);
endinterface

/* hdl/ssme_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set merge engine controller
// Accepts load and run words, sequences the priming, merge walk and final
// result of a run, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module ssme_ctrl (
  input  logic             clk,
  input  logic             rst,
  ssme_in_if.sink          item,
  input  ssme_pkg::status_t status,
  output ssme_pkg::cmd_t    cmd
);
  import ssme_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item.valid && item.kind == KIND_RUN) begin
          state_next = ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (!status.active) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs: handshake and datapath commands.
  always_comb begin
    cmd        = '0;
    item.ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          case (item.kind)
            KIND_LOAD_A: cmd.load_a = 1'b1;
            KIND_LOAD_B: cmd.load_b = 1'b1;
            default:     cmd        = '0;
          endcase
        end
      end
      ST_PRIME: begin
        cmd.start = 1'b1;
      end
      ST_WALK: begin
        cmd.step = status.active && status.out_free;
      end
      ST_FINISH: begin
        cmd.finish = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* hdl/ssme_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set merge engine datapath
// Holds both list memories, the counts, the mode register and the walk
// pointers, compares one pair of elements per step and drives the result
// register through a one-deep holding stage that settles the last flag.
// ----------------------------------------------------------------------------
module ssme_datapath #(
  parameter int LIST_CAPACITY = ssme_pkg::LIST_CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata,
  input  logic signed [31:0]  load_value,
  input  ssme_pkg::cmd_t      cmd,
  output ssme_pkg::status_t   status,
  ssme_out_if.source          result
);
  import ssme_pkg::*;

  localparam int CW = $clog2(LIST_CAPACITY + 1);
  localparam int AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam logic [CW-1:0] CAP = CW'(LIST_CAPACITY);

  logic [MODE_W-1:0] mode;
  logic [CW-1:0]     count_a;
  logic [CW-1:0]     count_b;
  logic              overflow_flag;

  logic [DATA_W-1:0] list_a_store [LIST_CAPACITY];
  logic [DATA_W-1:0] list_b_store [LIST_CAPACITY];
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;

  logic [CW-1:0]     pa;
  logic [CW-1:0]     pb;
  logic [CW-1:0]     pa_next;
  logic [CW-1:0]     pb_next;
  logic              fail;
  logic              pend_valid;
  logic [DATA_W-1:0] pend_value;

  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  logic              out_has;
  logic              out_cont;
  logic              out_ovf;
  logic              out_last;

  logic a_full;
  logic b_full;
  logic a_ok;
  logic b_ok;
  logic a_lt;
  logic a_gt;
  logic eq;
  logic active;
  logic adv_a;
  logic adv_b;
  logic emit;
  logic set_fail;
  logic emit_push;
  logic final_has;

  assign a_full = (count_a == CAP);
  assign b_full = (count_b == CAP);
  assign a_ok   = (pa < count_a);
  assign b_ok   = (pb < count_b);
  assign a_lt   = $signed(rd_a) < $signed(rd_b);
  assign a_gt   = $signed(rd_a) > $signed(rd_b);
  assign eq     = (rd_a == rd_b);

  // Per-mode decision for one step of the two-pointer walk.
  always_comb begin
    active   = 1'b0;
    adv_a    = 1'b0;
    adv_b    = 1'b0;
    emit     = 1'b0;
    set_fail = 1'b0;
    case (mode)
      MODE_INTERSECT: begin
        active = a_ok && b_ok;
        adv_a  = !a_gt;
        adv_b  = !a_lt;
        emit   = eq;
      end
      MODE_DIFF: begin
        active = a_ok;
        if (!b_ok) begin
          adv_a = 1'b1;
          emit  = 1'b1;
        end else begin
          adv_a = !a_gt;
          adv_b = !a_lt;
          emit  = a_lt;
        end
      end
      MODE_SUBSET: begin
        active   = !fail && a_ok && b_ok;
        set_fail = a_gt;
        adv_a    = !a_gt;
        adv_b    = eq;
      end
      default: begin
        active = 1'b0;
      end
    endcase
  end

  assign status.active   = active;
  assign status.out_free = !out_valid || result.ready;

  // Pointer update; the memories read ahead at the next pointer.
  always_comb begin
    pa_next = pa;
    pb_next = pb;
    if (cmd.finish) begin
      pa_next = '0;
      pb_next = '0;
    end else if (cmd.step) begin
      if (adv_a) begin
        pa_next = pa + CW'(1);
      end
      if (adv_b) begin
        pb_next = pb + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pa <= '0;
      pb <= '0;
    end else begin
      pa <= pa_next;
      pb <= pb_next;
    end
  end

  // List memories: written at the fill count, read at the walk pointer.
  always_ff @(posedge clk) begin
    if (cmd.load_a && !a_full) begin
      list_a_store[count_a[AW-1:0]] <= load_value;
    end
    rd_a <= list_a_store[pa_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_b && !b_full) begin
      list_b_store[count_b[AW-1:0]] <= load_value;
    end
    rd_b <= list_b_store[pb_next[AW-1:0]];
  end

  // Mode register, fill counts and overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_INTERSECT;
      count_a       <= '0;
      count_b       <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      if (cmd.finish) begin
        count_a       <= '0;
        count_b       <= '0;
        overflow_flag <= 1'b0;
      end else begin
        if (cmd.load_a) begin
          if (a_full) begin
            overflow_flag <= 1'b1;
          end else begin
            count_a <= count_a + CW'(1);
          end
        end
        if (cmd.load_b) begin
          if (b_full) begin
            overflow_flag <= 1'b1;
          end else begin
            count_b <= count_b + CW'(1);
          end
        end
      end
    end
  end

  // Subset failure flag and the holding stage for the newest element.
  always_ff @(posedge clk) begin
    if (rst) begin
      fail       <= 1'b0;
      pend_valid <= 1'b0;
    end else if (cmd.start) begin
      fail       <= (count_a < count_b);
      pend_valid <= 1'b0;
    end else if (cmd.step) begin
      if (set_fail) begin
        fail <= 1'b1;
      end
      if (emit) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      pend_value <= rd_a;
    end
  end

  // A held element moves out once a newer one arrives; the final word of
  // the run carries the last flag.
  assign emit_push = cmd.step && emit && pend_valid;
  assign final_has = pend_valid && (mode == MODE_INTERSECT || mode == MODE_DIFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_push || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_push) begin
      out_value <= pend_value;
      out_has   <= 1'b1;
      out_cont  <= 1'b0;
      out_ovf   <= overflow_flag;
      out_last  <= 1'b0;
    end else if (cmd.finish) begin
      out_value <= final_has ? pend_value : '0;
      out_has   <= final_has;
      out_cont  <= (mode == MODE_SUBSET) && !fail && !b_ok;
      out_ovf   <= overflow_flag;
      out_last  <= 1'b1;
    end
  end

  assign result.valid     = out_valid;
  assign result.value_res = out_value;
  assign result.has_value = out_has;
  assign result.contained = out_cont;
  assign result.overflow  = out_ovf;
  assign result.last      = out_last;

endmodule

/* hdl/sorted_set_merge_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set merge engine
// Loads two ascending lists of signed 32-bit values and merges them by mode.
// ----------------------------------------------------------------------------
// Usage: the item channel takes one word per cycle while idle; kind 0 appends
// value to list A, kind 1 appends it to list B, kind 2 starts a run and kind
// 3 is ignored. A load into a full list is dropped and reported as overflow
// in every result word of the next run. The mode register is written through
// cfg_we/cfg_wdata: 0 gives the intersection, 1 gives A minus B, 2 gives one
// word with contained set if B lies in A. The user must write it only while
// the engine is idle; the block itself does not enforce this. A run has a
// set-up state after the run word, then a merge walk of at most count_a +
// count_b comparisons, then a closing state that registers the final word;
// the walk compares one element pair per cycle from registered memory reads.
// Input is not taken during a run. Results leave through a single output
// register; while a word waits there with ready low the walk pauses. An
// empty answer gives one word with has_value clear. The final word of a run
// carries last. Reset clears the counts, overflow flag and mode; list
// contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module sorted_set_merge_engine #(
  parameter int LIST_CAPACITY = ssme_pkg::LIST_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  ssme_in_if.sink    item,
  ssme_out_if.source result
);
  import ssme_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing of loads and runs.
  ssme_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .status (status),
    .cmd    (cmd)
  );

  // Storage, merge walk and result register.
  ssme_datapath #(
    .LIST_CAPACITY (LIST_CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .load_value (item.value),
    .cmd        (cmd),
    .status     (status),
    .result     (result)
  );

endmodule
